@@ design/ht_pkg.sv @@
package ht_pkg;

  localparam int unsigned DefaultTaps = 31;
  localparam int unsigned SampleW     = 16;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StFlush,
    StDone
  } ht_state_e;

  typedef struct packed {
    logic clr;
    logic rd;
    logic is_i;
    logic hit;
  } ht_cmd_t;

  function automatic int unsigned len_of(int unsigned taps);
    return (taps < 3) ? 3 : (taps | 1);
  endfunction

  function automatic int unsigned mid_of(int unsigned len);
    return (len - 1) >> 1;
  endfunction

  function automatic int unsigned first_tap_of(int unsigned mid);
    return ((mid & 1) != 0) ? 0 : 1;
  endfunction

  function automatic int unsigned tap_count_of(int unsigned mid);
    return ((mid & 1) != 0) ? mid + 1 : mid;
  endfunction

endpackage

@@ design/ht_in_if.sv @@
interface ht_in_if;
  import ht_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

@@ design/ht_out_if.sv @@
interface ht_out_if;
  import ht_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] in_phase;
  logic signed [SampleW-1:0] quadrature;

  modport source (output valid, output in_phase, output quadrature, input ready);
  modport sink (input valid, input in_phase, input quadrature, output ready);
endinterface

@@ design/ht_ram.sv @@
module ht_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 31,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ design/ht_ctrl.sv @@
module ht_ctrl #(
  parameter int unsigned Taps = ht_pkg::DefaultTaps,
  localparam int unsigned Len = ht_pkg::len_of(Taps),
  localparam int unsigned AW  = $clog2(Len)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            wr_en_o,
  output logic [AW-1:0]   wr_addr_o,
  output logic            rd_en_o,
  output logic [AW-1:0]   rd_addr_o,
  output ht_pkg::ht_cmd_t cmd_o,
  output logic            load_o,
  input  logic            out_free_i
);
  import ht_pkg::*;

  localparam int unsigned Mid   = mid_of(Len);
  localparam int unsigned I0    = first_tap_of(Mid);
  localparam int unsigned Ntaps = tap_count_of(Mid);
  localparam int unsigned FW    = $clog2(Len + 1);
  localparam int unsigned SW    = $clog2(Ntaps + 1);

  ht_state_e     state_q, state_d;
  logic [SW-1:0] step_q;
  logic [AW-1:0] slot_q;
  logic [FW-1:0] fill_q;
  logic [AW-1:0] iaddr_q;
  logic [AW-1:0] taddr_q;
  ht_cmd_t       cmd_q, cmd_d;
  logic          accept;
  logic [AW-1:0] taddr_next;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StRead;
        end
      end
      StRead: begin
        if (step_q == SW'(Ntaps)) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        state_d = StDone;
      end
      StDone: begin
        if (out_free_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == StIdle);
    wr_en_o    = accept;
    wr_addr_o  = slot_q;
    rd_en_o    = (state_q == StRead);
    rd_addr_o  = (step_q == '0) ? iaddr_q : taddr_q;
    load_o     = (state_q == StDone) && out_free_i;
    cmd_d.clr  = accept;
    cmd_d.rd   = (state_q == StRead);
    cmd_d.is_i = (step_q == '0);
    cmd_d.hit  = (FW'(rd_addr_o) < fill_q);
  end

  assign cmd_o      = cmd_q;
  assign taddr_next = (taddr_q >= AW'(2)) ? taddr_q - AW'(2) : taddr_q + AW'(Len - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      slot_q  <= '0;
      fill_q  <= '0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      cmd_q   <= cmd_d;
      if (accept) begin
        step_q <= '0;
        slot_q <= (slot_q == AW'(Len - 1)) ? '0 : slot_q + 1'b1;
        if (fill_q != FW'(Len)) begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (state_q == StRead) begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      iaddr_q <= (slot_q >= AW'(Mid)) ? slot_q - AW'(Mid) : slot_q + AW'(Len - Mid);
      taddr_q <= (slot_q >= AW'(I0)) ? slot_q - AW'(I0) : slot_q + AW'(Len - I0);
    end else if ((state_q == StRead) && (step_q != '0)) begin
      taddr_q <= taddr_next;
    end
  end

endmodule

@@ design/ht_mac.sv @@
module ht_mac #(
  parameter int unsigned Taps = ht_pkg::DefaultTaps
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ht_pkg::ht_cmd_t            cmd_i,
  input  logic [ht_pkg::SampleW-1:0] rd_data_i,
  input  logic                       load_i,
  output logic                       out_free_o,
  ht_out_if.source                   out_o
);
  import ht_pkg::*;

  localparam int unsigned Len   = len_of(Taps);
  localparam int unsigned Mid   = mid_of(Len);
  localparam int unsigned I0    = first_tap_of(Mid);
  localparam int unsigned Ntaps = tap_count_of(Mid);
  localparam int unsigned TW    = $clog2(Ntaps);
  localparam int unsigned AccW  = 33 + $clog2(Ntaps);
  localparam int unsigned RW    = AccW - 15;

  localparam longint PiQ30       = 64'sd3373259426;
  localparam longint TwoPiInvQ30 = 64'sd683565276;
  localparam longint W0Q30       = 64'sd450971566;
  localparam longint W2Q30       = 64'sd85899346;
  localparam longint OneQ30      = 64'sd1073741824;

  localparam logic signed [RW-1:0]      QMax  = RW'(32767);
  localparam logic signed [RW-1:0]      QMin  = RW'(-32768);
  localparam logic signed [SampleW-1:0] SatHi = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SatLo = 16'sh8000;

  // Long division of a nonnegative dividend by a positive divisor, used only
  // while the coefficient table is built.
  function automatic longint quot_of(longint num, longint den);
    longint quo;
    longint rem;
    int     b;
    quo = 64'sd0;
    rem = 64'sd0;
    for (b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
      quo = quo <<< 1;
      if (rem >= den) begin
        rem = rem - den;
        quo = quo | 64'sd1;
      end
    end
    return quo;
  endfunction

  function automatic longint cospi_mid(longint num);
    longint r;
    longint theta;
    longint th2;
    longint term;
    longint sum;
    longint den;
    int     i;
    bit     neg;
    den  = longint'(Mid);
    neg  = 1'b0;
    r    = num - 2 * den * quot_of(num, 2 * den);
    if (r > den) r = 2 * den - r;
    if (2 * r > den) begin
      r   = den - r;
      neg = 1'b1;
    end
    theta = quot_of(PiQ30 * r, den);
    th2   = (theta * theta) >> 30;
    term  = OneQ30;
    sum   = OneQ30;
    for (i = 1; i <= 12; i++) begin
      term = (term * th2) >> 30;
      term = quot_of(term, longint'((2 * i - 1) * (2 * i)));
      if (i[0]) sum = sum - term;
      else sum = sum + term;
    end
    return neg ? -sum : sum;
  endfunction

  function automatic logic signed [15:0] coef_at(int unsigned n);
    longint k;
    longint kabs;
    longint h;
    longint w;
    longint c1;
    longint c2;
    longint prod;
    longint mag;
    longint q;
    k    = longint'(n) - longint'(Mid);
    kabs = (k < 0) ? -k : k;
    h    = quot_of(TwoPiInvQ30, kabs);
    if (k < 0) h = -h;
    c1   = cospi_mid(longint'(n));
    c2   = cospi_mid(longint'(2 * n));
    w    = W0Q30 - c1 / 2 + (W2Q30 * c2) / OneQ30;
    prod = h * w;
    mag  = (prod < 0) ? -prod : prod;
    mag  = (mag + (64'sd1 <<< 44)) >>> 45;
    if (mag > 32768) mag = 32768;
    q = (prod < 0) ? -mag : mag;
    if (q > 32767) q = 32767;
    return q[15:0];
  endfunction

  logic signed [SampleW-1:0] coef_tab [Ntaps];

  for (genvar g = 0; g < Ntaps; g++) begin : g_coef
    localparam logic signed [SampleW-1:0] CoefVal = coef_at(I0 + 2 * g);
    assign coef_tab[g] = CoefVal;
  end

  logic [TW-1:0]             tap_q;
  logic signed [AccW-1:0]    acc_q;
  logic signed [SampleW-1:0] iph_q;
  logic signed [SampleW-1:0] data;
  logic signed [31:0]        prod;
  logic signed [AccW-1:0]    rnd;
  logic signed [RW-1:0]      shifted;
  logic signed [SampleW-1:0] q_sat;
  logic                      valid_q;
  logic signed [SampleW-1:0] in_phase_q;
  logic signed [SampleW-1:0] quad_q;

  assign data    = cmd_i.hit ? $signed(rd_data_i) : '0;
  assign prod    = coef_tab[tap_q] * data;
  assign rnd     = acc_q + AccW'(16384);
  assign shifted = RW'(rnd >>> 15);

  always_comb begin
    if (shifted > QMax) begin
      q_sat = SatHi;
    end else if (shifted < QMin) begin
      q_sat = SatLo;
    end else begin
      q_sat = shifted[SampleW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      tap_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.rd && !cmd_i.is_i) begin
      tap_q <= tap_q + 1'b1;
      acc_q <= acc_q + AccW'(prod);
    end
    if (cmd_i.rd && cmd_i.is_i) begin
      iph_q <= data;
    end
    if (load_i) begin
      in_phase_q <= iph_q;
      quad_q     <= q_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign out_free_o       = !valid_q || out_o.ready;
  assign out_o.valid      = valid_q;
  assign out_o.in_phase   = in_phase_q;
  assign out_o.quadrature = quad_q;

endmodule

@@ design/hilbert_transformer_iq.sv @@
// Each accepted word passes through the read, flush and done states. In the read state the
// centre entry is read first, then the Ntaps odd-offset taps (16 for 31 taps).
// A new word is accepted only in the idle state, after the previous result is loaded for output;
// the single multiply-accumulate reads one delay-line entry per cycle from the history memory.
// Reset clears the control state and the fill count; delay-line entries not yet
// written read as zero, so no clearing pass is needed.
module hilbert_transformer_iq #(
  parameter int unsigned Taps = ht_pkg::DefaultTaps
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ht_in_if.sink    in_i,
  ht_out_if.source out_o
);
  import ht_pkg::*;

  localparam int unsigned Len = len_of(Taps);
  localparam int unsigned AW  = $clog2(Len);

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [SampleW-1:0] rd_data;
  ht_cmd_t            cmd;
  logic               load;
  logic               out_free;

  ht_ctrl #(
    .Taps(Taps)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .cmd_o      (cmd),
    .load_o     (load),
    .out_free_i (out_free)
  );

  ht_ram #(
    .Width(SampleW),
    .Depth(Len)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_i.sample),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ht_mac #(
    .Taps(Taps)
  ) u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_data_i  (rd_data),
    .load_i     (load),
    .out_free_o (out_free),
    .out_o      (out_o)
  );

endmodule

@@ sim/tb_hilbert_transformer_iq.sv @@
`timescale 1ns / 100ps

module tb_hilbert_transformer_iq;

  localparam int unsigned Taps     = ht_pkg::DefaultTaps;
  localparam int unsigned SW       = ht_pkg::SampleW;
  localparam int unsigned Len      = (Taps < 3) ? 3 : (Taps | 1);
  localparam int unsigned Mid      = (Len - 1) / 2;
  localparam int unsigned NumWords = 1550;
  localparam int unsigned Settle   = 2 * (Mid + 6);

  localparam longint unsigned PiQ30        = 64'd3373259426;
  localparam longint          OneQ30       = 64'sd1073741824;
  localparam longint          TwoOverPiQ30 = 64'sd683565276;
  localparam longint          Win0Q30      = 64'sd450971566;
  localparam longint          Win2Q30      = 64'sd85899346;

  localparam logic signed [SW-1:0] SampleMax = 16'sh7fff;
  localparam logic signed [SW-1:0] SampleMin = 16'sh8000;

  typedef struct packed {
    logic signed [SW-1:0] in_phase;
    logic signed [SW-1:0] quadrature;
  } iq_pair_t;

  typedef enum int {
    SegNoise,
    SegSmall,
    SegExtreme,
    SegSaturate,
    SegImpulse,
    SegConstant
  } seg_kind_e;

  class iq_scoreboard;
    int                   coef [Len];
    logic signed [SW-1:0] delay_line [Len];
    int unsigned          slot;
    iq_pair_t             expected_pairs [$];
    int unsigned          mismatch_count;

    function longint cos_pi_q30(int unsigned num, int unsigned den);
      int unsigned     r;
      bit              neg;
      longint unsigned theta;
      longint unsigned theta_sq;
      longint unsigned term;
      longint          total;
      int unsigned     i;
      r   = num % (2 * den);
      neg = 1'b0;
      if (r > den) begin
        r = 2 * den - r;
      end
      if (2 * r > den) begin
        r   = den - r;
        neg = 1'b1;
      end
      theta    = (PiQ30 * 64'(r)) / 64'(den);
      theta_sq = (theta * theta) >> 30;
      term     = 64'(OneQ30);
      total    = OneQ30;
      for (i = 1; i <= 12; i++) begin
        term = (term * theta_sq) >> 30;
        term = term / 64'((2 * i - 1) * (2 * i));
        if (i % 2 == 1) begin
          total -= longint'(term);
        end else begin
          total += longint'(term);
        end
      end
      return neg ? -total : total;
    endfunction

    function new();
      int              n;
      int              k;
      longint          h;
      longint          w;
      longint          prod;
      longint          q;
      longint unsigned mag;
      for (n = 0; n < Len; n++) begin
        delay_line[n] = '0;
        k = n - int'(Mid);
        if (k % 2 == 0) begin
          coef[n] = 0;
          continue;
        end
        h = TwoOverPiQ30 / longint'((k < 0) ? -k : k);
        if (k < 0) begin
          h = -h;
        end
        w = Win0Q30 - cos_pi_q30(n, Mid) / 2
            + (Win2Q30 * cos_pi_q30(2 * n, Mid)) / OneQ30;
        prod = h * w;
        mag  = (prod < 0) ? longint'(-prod) : longint'(prod);
        mag  = (mag + (64'd1 << 44)) >> 45;
        if (mag > 64'd32768) begin
          mag = 64'd32768;
        end
        q = (prod < 0) ? -longint'(mag) : longint'(mag);
        if (q > 32767) begin
          q = 32767;
        end
        coef[n] = int'(q);
      end
      slot           = 0;
      mismatch_count = 0;
    endfunction

    function void note_sample(logic signed [SW-1:0] sample);
      longint      acc;
      longint      rounded;
      int unsigned i;
      int unsigned j;
      iq_pair_t    pair;
      delay_line[slot] = sample;
      acc = 0;
      j   = slot;
      for (i = 0; i < Len; i++) begin
        acc += longint'(coef[i]) * longint'(delay_line[j]);
        j = (j == 0) ? Len - 1 : j - 1;
      end
      rounded = (acc + 16384) >>> 15;
      if (rounded > 32767) begin
        rounded = 32767;
      end
      if (rounded < -32768) begin
        rounded = -32768;
      end
      pair.in_phase   = delay_line[(slot + Len - Mid) % Len];
      pair.quadrature = rounded[SW-1:0];
      expected_pairs.push_back(pair);
      slot = (slot + 1) % Len;
    endfunction

    function void check_pair(logic signed [SW-1:0] in_phase,
                             logic signed [SW-1:0] quadrature);
      iq_pair_t pair;
      if (expected_pairs.size() == 0) begin
        $error("Unexpected result word: in_phase %0d, quadrature %0d", in_phase, quadrature);
        mismatch_count++;
        return;
      end
      pair = expected_pairs.pop_front();
      if (in_phase !== pair.in_phase) begin
        $error("in_phase mismatch: expected %0d, actual %0d", pair.in_phase, in_phase);
        mismatch_count++;
      end
      if (quadrature !== pair.quadrature) begin
        $error("quadrature mismatch: expected %0d, actual %0d", pair.quadrature, quadrature);
        mismatch_count++;
      end
    endfunction

    function int unsigned pending();
      return expected_pairs.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ht_in_if  in_if ();
  ht_out_if out_if ();

  hilbert_transformer_iq #(
    .Taps (Taps)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  iq_scoreboard sb;
  bit           in_quiet;
  bit           out_quiet;
  int unsigned  words_sent;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
      sb.note_sample(in_if.sample);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_pair(out_if.in_phase, out_if.quadrature);
    end
  end

  task automatic send_word(input logic signed [SW-1:0] sample);
    int unsigned gap;
    gap = in_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= sample;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    words_sent++;
  endtask

  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = out_quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      if ($urandom_range(0, 39) == 0) begin
        out_quiet = ~out_quiet;
      end
    end
  end

  initial begin
    int                   directed [17];
    seg_kind_e            kind;
    int unsigned          seg_len;
    int unsigned          j;
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] value;

    sb         = new();
    in_quiet   = 1'b0;
    out_quiet  = 1'b0;
    words_sent = 0;
    directed   = '{32767, -32768, 0, 1, -1, 16384, -16384, 21845, -21846,
                   32767, 32767, -32768, -32768, 0, 0, 255, -256};

    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    out_if.ready <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      send_word(SW'(directed[i]));
    end

    while (words_sent < NumWords) begin
      kind     = seg_kind_e'($urandom_range(0, 5));
      seg_len  = $urandom_range(1, 40);
      in_quiet = ($urandom_range(0, 3) == 0);
      case (kind)
        SegNoise: begin
          repeat (seg_len) send_word(SW'($urandom));
        end
        SegSmall: begin
          repeat (seg_len) send_word(SW'(int'($urandom_range(0, 128)) - 64));
        end
        SegExtreme: begin
          repeat (seg_len) send_word($urandom_range(0, 1) ? SampleMax : SampleMin);
        end
        SegSaturate: begin
          if ($urandom_range(0, 1) == 1) begin
            hi = SampleMax;
            lo = SampleMin;
          end else begin
            hi = SampleMin;
            lo = SampleMax;
          end
          for (j = 0; j < Len; j++) begin
            if (j < Mid) begin
              send_word(hi);
            end else if (j == Mid) begin
              send_word(SW'($urandom));
            end else begin
              send_word(lo);
            end
          end
        end
        SegImpulse: begin
          case ($urandom_range(0, 2))
            0: send_word(SampleMax);
            1: send_word(SampleMin);
            default: send_word(SW'($urandom));
          endcase
          repeat (seg_len) send_word('0);
        end
        default: begin
          value = SW'($urandom);
          repeat (seg_len) send_word(value);
        end
      endcase
    end
    in_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);

    if (sb.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
